### design/crcs_pkg.sv
package crcs_pkg;

  // Coordinate format of the ports
  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 12;

  // Phantom points can step one STEP beyond the port range
  localparam int PW = COORD_WIDTH + 1;
  // Spline coefficients reach twelve times a phantom coordinate
  localparam int CW = COORD_WIDTH + 4;

  // Samples per segment and per short set
  localparam int SEG_SAMPLES = 9;
  localparam int ERR_SAMPLES = 5;

  // Job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef logic signed [PW-1:0] pcoord_t;
  typedef pcoord_t [2:0] point_t;
  typedef logic signed [CW-1:0] coef_t;

  typedef struct packed {
    coef_t a0;
    coef_t a1;
    coef_t a2;
    coef_t a3;
  } axis_coef_t;

  // One segment (or one burst of error samples) for the back end
  typedef struct packed {
    logic             err;
    logic             last;
    axis_coef_t [2:0] axis;
  } seg_job_t;

  localparam pcoord_t STEP = pcoord_t'(((2 ** FRAC_BITS) + 5) / 10);

  // Cubic coefficients of one axis of a uniform Catmull-Rom segment, scaled by 2
  function automatic axis_coef_t seg_coef(input pcoord_t p0, input pcoord_t p1,
                                          input pcoord_t p2, input pcoord_t p3);
    axis_coef_t r;
    coef_t      e0;
    coef_t      e1;
    coef_t      e2;
    coef_t      e3;
    e0   = coef_t'(p0);
    e1   = coef_t'(p1);
    e2   = coef_t'(p2);
    e3   = coef_t'(p3);
    r.a0 = e1 <<< 1;
    r.a1 = e2 - e0;
    r.a2 = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
    r.a3 = e1 + (e1 <<< 1) - e2 - (e2 <<< 1) + e3 - e0;
    return r;
  endfunction

endpackage

### design/catmull_rom_curve_sampler.sv
// Catmull-Rom curve sampler. Control points of a set arrive one per transaction
// in signed Q4.12 with the last point marked by final_point; each segment between
// neighboring points is sampled nine times (t = 0.0 .. 0.8), with phantom points
// 0.1 beyond the first and last points, and a set of fewer than four points gives
// five (-1,-1,-1) samples flagged by too_few_points. run_end marks the last
// sample caused by a point. The back end produces one sample per cycle unless
// out_stall holds the output, so a point gives nine samples (eighteen for a final
// point that closes a set of four or more, five for a short set, none for the
// first two points); that one-sample-per-cycle datapath sets the rate. Each
// issued sample is registered through the five-stage datapath. The front end
// accepts points while its four-entry job queue has room, and holds its input
// after a final point that closes a set of four or more until the closing
// segment is queued; a point can be taken while earlier samples are still being
// computed or held.
module catmull_rom_curve_sampler (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_stall,
  input  logic signed [crcs_pkg::COORD_WIDTH-1:0]     point_x,
  input  logic signed [crcs_pkg::COORD_WIDTH-1:0]     point_y,
  input  logic signed [crcs_pkg::COORD_WIDTH-1:0]     point_z,
  input  logic                                        final_point,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic signed [crcs_pkg::COORD_WIDTH-1:0]     curve_x,
  output logic signed [crcs_pkg::COORD_WIDTH-1:0]     curve_y,
  output logic signed [crcs_pkg::COORD_WIDTH-1:0]     curve_z,
  output logic                                        too_few_points,
  output logic                                        run_end
);

  logic               push;
  crcs_pkg::seg_job_t push_job;
  logic               q_full;
  logic               pop;
  logic               q_nonempty;
  crcs_pkg::seg_job_t head_job;

  // Classify points and build segment jobs
  crcs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .final_point (final_point),
    .push        (push),
    .push_job    (push_job),
    .q_full      (q_full)
  );

  // Decouple point intake from sample output
  crcs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .nonempty (q_nonempty),
    .head_job (head_job)
  );

  // Evaluate samples
  crcs_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_nonempty     (q_nonempty),
    .head_job       (head_job),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .curve_x        (curve_x),
    .curve_y        (curve_y),
    .curve_z        (curve_z),
    .too_few_points (too_few_points),
    .run_end        (run_end)
  );

endmodule

### design/crcs_queue.sv
module crcs_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  crcs_pkg::seg_job_t  push_job,
  output logic                full,
  input  logic                pop,
  output logic                nonempty,
  output crcs_pkg::seg_job_t  head_job
);

  crcs_pkg::seg_job_t          entries [crcs_pkg::QDEPTH];
  logic [crcs_pkg::QAW-1:0]    wptr;
  logic [crcs_pkg::QAW-1:0]    rptr;
  logic [crcs_pkg::QAW:0]      count;

  assign full     = (count == (crcs_pkg::QAW + 1)'(crcs_pkg::QDEPTH));
  assign nonempty = (count != '0);
  assign head_job = entries[rptr];

  // Store incoming jobs
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### design/crcs_front.sv
module crcs_front (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_stall,
  input  logic signed [crcs_pkg::COORD_WIDTH-1:0]     point_x,
  input  logic signed [crcs_pkg::COORD_WIDTH-1:0]     point_y,
  input  logic signed [crcs_pkg::COORD_WIDTH-1:0]     point_z,
  input  logic                                        final_point,
  output logic                                        push,
  output crcs_pkg::seg_job_t                          push_job,
  input  logic                                        q_full
);

  crcs_pkg::point_t   win0;
  crcs_pkg::point_t   win1;
  crcs_pkg::point_t   win2;
  crcs_pkg::point_t   first_pt;
  logic [1:0]         points_seen;
  logic               pend;
  crcs_pkg::seg_job_t pend_job;

  crcs_pkg::point_t   cur;
  crcs_pkg::point_t   lead;
  crcs_pkg::point_t   tail;
  crcs_pkg::seg_job_t job1;
  crcs_pkg::seg_job_t job2;
  logic               accept;
  logic               emits;
  logic               short_set;

  assign cur[0] = crcs_pkg::pcoord_t'(point_x);
  assign cur[1] = crcs_pkg::pcoord_t'(point_y);
  assign cur[2] = crcs_pkg::pcoord_t'(point_z);

  // Hold input while a closing segment waits or the queue is full
  assign in_stall  = pend | q_full;
  assign accept    = in_valid & ~in_stall;
  assign short_set = final_point & (points_seen != 2'd3);
  assign emits     = final_point | points_seen[1];

  // Classify the point and build its segment jobs
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lead[i] = first_pt[i] - crcs_pkg::STEP;
      tail[i] = cur[i] + crcs_pkg::STEP;
    end
    job1 = '0;
    job2 = '0;
    if (short_set) begin
      job1.err  = 1'b1;
      job1.last = 1'b1;
    end else if (points_seen == 2'd2) begin
      job1.last = 1'b1;
      for (int i = 0; i < 3; i++) begin
        job1.axis[i] = crcs_pkg::seg_coef(lead[i], win1[i], win2[i], cur[i]);
      end
    end else begin
      job1.last = ~final_point;
      for (int i = 0; i < 3; i++) begin
        job1.axis[i] = crcs_pkg::seg_coef(win0[i], win1[i], win2[i], cur[i]);
      end
    end
    job2.last = 1'b1;
    for (int i = 0; i < 3; i++) begin
      job2.axis[i] = crcs_pkg::seg_coef(win1[i], win2[i], cur[i], tail[i]);
    end
  end

  // Push the waiting closing segment first, else the new point's job
  assign push     = pend ? ~q_full : (accept & emits);
  assign push_job = pend ? pend_job : job1;

  always_ff @(posedge clk) begin
    if (accept && final_point && !short_set) begin
      pend_job <= job2;
    end
  end

  // Track the point window and set progress
  always_ff @(posedge clk) begin
    if (rst) begin
      win0        <= '0;
      win1        <= '0;
      win2        <= '0;
      first_pt    <= '0;
      points_seen <= '0;
      pend        <= 1'b0;
    end else begin
      if (pend && !q_full) begin
        pend <= 1'b0;
      end
      if (accept) begin
        if (final_point) begin
          win0        <= '0;
          win1        <= '0;
          win2        <= '0;
          first_pt    <= '0;
          points_seen <= '0;
          pend        <= ~short_set;
        end else begin
          win0 <= win1;
          win1 <= win2;
          win2 <= cur;
          if (points_seen == 2'd0) begin
            first_pt <= cur;
          end
          if (points_seen != 2'd3) begin
            points_seen <= points_seen + 1'b1;
          end
        end
      end
    end
  end

endmodule

### design/crcs_back.sv
module crcs_back (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        q_nonempty,
  input  crcs_pkg::seg_job_t                          head_job,
  output logic                                        pop,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic signed [crcs_pkg::COORD_WIDTH-1:0]     curve_x,
  output logic signed [crcs_pkg::COORD_WIDTH-1:0]     curve_y,
  output logic signed [crcs_pkg::COORD_WIDTH-1:0]     curve_z,
  output logic                                        too_few_points,
  output logic                                        run_end
);

  localparam int TW  = crcs_pkg::CW + 11;
  localparam int NW  = TW + 2;
  localparam int XW  = crcs_pkg::COORD_WIDTH + 8;
  localparam int SH  = XW + 7;
  localparam int RW  = XW + 1;
  localparam int QW  = XW + RW - SH;
  localparam int OW  = crcs_pkg::COORD_WIDTH;
  localparam int KW  = $clog2(crcs_pkg::SEG_SAMPLES);

  localparam logic [RW-1:0] RECIP = RW'(((64'd1 << SH) + 64'd124) / 64'd125);
  localparam logic signed [QW:0] MAXV = (QW + 1)'((2 ** (OW - 1)) - 1);
  localparam logic signed [QW:0] MINV = -(QW + 1)'(2 ** (OW - 1));
  localparam logic signed [OW-1:0] ERR_VAL = -OW'(2 ** crcs_pkg::FRAC_BITS);
  localparam logic [KW-1:0] SEG_LAST = KW'(crcs_pkg::SEG_SAMPLES - 1);
  localparam logic [KW-1:0] ERR_LAST = KW'(crcs_pkg::ERR_SAMPLES - 1);

  typedef logic signed [TW-1:0] term_t;
  typedef logic signed [NW-1:0] sum_t;

  crcs_pkg::seg_job_t job;
  logic               have;
  logic [KW-1:0]      k;

  logic               s1_valid, s1_err, s1_end;
  term_t              s1_t0 [3];
  term_t              s1_t1 [3];
  term_t              s1_t2 [3];
  term_t              s1_t3 [3];
  logic               s2_valid, s2_err, s2_end;
  sum_t               s2_n [3];
  logic               s3_valid, s3_err, s3_end;
  logic [XW-1:0]      s3_x [3];
  logic               s3_neg [3];
  logic               s4_valid, s4_err, s4_end;
  logic [XW+RW-1:0]   s4_p [3];
  logic               s4_neg [3];
  logic signed [OW-1:0] s5_v [3];

  logic               en;
  logic               issue;
  logic               done;
  logic signed [11:0] c1;
  logic signed [11:0] c2;
  logic signed [11:0] c3;
  sum_t               absn [3];
  sum_t               rnd [3];
  logic [QW-1:0]      q [3];
  logic signed [QW:0] sq [3];
  logic signed [OW-1:0] sat [3];

  // Advance the whole sample pipeline unless the output is held
  assign en    = ~(out_valid & out_stall);
  assign issue = have & en;
  assign done  = issue & (k == (job.err ? ERR_LAST : SEG_LAST));
  assign pop   = q_nonempty & (~have | done);

  // Time-step weights: 100k, 10k^2 and k^3
  always_comb begin
    case (k)
      4'd0:    begin c1 = 12'sd0;   c2 = 12'sd0;   c3 = 12'sd0;   end
      4'd1:    begin c1 = 12'sd100; c2 = 12'sd10;  c3 = 12'sd1;   end
      4'd2:    begin c1 = 12'sd200; c2 = 12'sd40;  c3 = 12'sd8;   end
      4'd3:    begin c1 = 12'sd300; c2 = 12'sd90;  c3 = 12'sd27;  end
      4'd4:    begin c1 = 12'sd400; c2 = 12'sd160; c3 = 12'sd64;  end
      4'd5:    begin c1 = 12'sd500; c2 = 12'sd250; c3 = 12'sd125; end
      4'd6:    begin c1 = 12'sd600; c2 = 12'sd360; c3 = 12'sd216; end
      4'd7:    begin c1 = 12'sd700; c2 = 12'sd490; c3 = 12'sd343; end
      4'd8:    begin c1 = 12'sd800; c2 = 12'sd640; c3 = 12'sd512; end
      default: begin c1 = 12'sd0;   c2 = 12'sd0;   c3 = 12'sd0;   end
    endcase
  end

  // Load jobs and step through their samples
  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
      k    <= '0;
    end else begin
      if (pop) begin
        have <= 1'b1;
        k    <= '0;
      end else if (done) begin
        have <= 1'b0;
      end else if (issue) begin
        k <= k + 1'b1;
      end
    end
  end

  // Rounding and saturation helpers per axis
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      absn[i] = s2_n[i][NW-1] ? -s2_n[i] : s2_n[i];
      rnd[i]  = absn[i] + NW'(1000);
      q[i]    = s4_p[i][XW+RW-1:SH];
      sq[i]   = s4_neg[i] ? -signed'({1'b0, q[i]}) : signed'({1'b0, q[i]});
      if (sq[i] > MAXV) begin
        sat[i] = MAXV[OW-1:0];
      end else if (sq[i] < MINV) begin
        sat[i] = MINV[OW-1:0];
      end else begin
        sat[i] = sq[i][OW-1:0];
      end
    end
  end

  // Sample datapath: terms, sum, rounded magnitude, reciprocal multiply, saturate
  always_ff @(posedge clk) begin
    if (en) begin
      s1_err <= job.err;
      s1_end <= job.last & done;
      s2_err <= s1_err;
      s2_end <= s1_end;
      s3_err <= s2_err;
      s3_end <= s2_end;
      s4_err <= s3_err;
      s4_end <= s3_end;
      too_few_points <= s4_err;
      run_end        <= s4_end;
      for (int i = 0; i < 3; i++) begin
        s1_t0[i]  <= term_t'(job.axis[i].a0) * term_t'(12'sd1000);
        s1_t1[i]  <= term_t'(job.axis[i].a1) * term_t'(c1);
        s1_t2[i]  <= term_t'(job.axis[i].a2) * term_t'(c2);
        s1_t3[i]  <= term_t'(job.axis[i].a3) * term_t'(c3);
        s2_n[i]   <= sum_t'(s1_t0[i]) + sum_t'(s1_t1[i]) + sum_t'(s1_t2[i])
                     + sum_t'(s1_t3[i]);
        s3_x[i]   <= rnd[i][XW+3:4];
        s3_neg[i] <= s2_n[i][NW-1];
        s4_p[i]   <= (XW + RW)'(s3_x[i]) * (XW + RW)'(RECIP);
        s4_neg[i] <= s3_neg[i];
        s5_v[i]   <= s4_err ? ERR_VAL : sat[i];
      end
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= issue;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

  assign curve_x = s5_v[0];
  assign curve_y = s5_v[1];
  assign curve_z = s5_v[2];

endmodule
